### sv/vrmp_pkg.sv
// ----------------------------------------------------------------------------
// vrmp_pkg
// shared types and constants for the running mean and peak capture block
// ----------------------------------------------------------------------------
package vrmp_pkg;

  localparam int MEAN_WIDTH = 32;
  localparam int NUM_AXES   = 3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } vrmp_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic update;
    logic out_load;
  } vrmp_cmd_t;

  typedef struct packed {
    logic div_last;
  } vrmp_stat_t;

endpackage

### sv/vrmp_if.sv
// ----------------------------------------------------------------------------
// vrmp_if
// valid/ready channels for sample requests and results
// ----------------------------------------------------------------------------
interface vrmp_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [SAMPLE_WIDTH-1:0] sample_z;
  logic                           restart;

  modport source (output valid, sample_x, sample_y, sample_z, restart, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, restart, output ready);
endinterface

interface vrmp_out_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [31:0]             mean_x;
  logic signed [31:0]             mean_y;
  logic signed [31:0]             mean_z;
  logic signed [SAMPLE_WIDTH-1:0] peak_x;
  logic signed [SAMPLE_WIDTH-1:0] peak_y;
  logic signed [SAMPLE_WIDTH-1:0] peak_z;
  logic        [COUNT_WIDTH-1:0]  samples_seen;

  modport source (output valid, mean_x, mean_y, mean_z, peak_x, peak_y, peak_z,
                  samples_seen, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, peak_x, peak_y, peak_z,
                  samples_seen, output ready);
endinterface

### sv/vrmp_ctrl.sv
// ----------------------------------------------------------------------------
// vrmp_ctrl
// sequencer: load, prepare, serial divide, update, hand off result
// ----------------------------------------------------------------------------
module vrmp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vrmp_pkg::vrmp_cmd_t  cmd_o,
  input  vrmp_pkg::vrmp_stat_t stat_i
);
  import vrmp_pkg::*;

  vrmp_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/vrmp_dpath.sv
// ----------------------------------------------------------------------------
// vrmp_dpath
// statistics registers, three restoring divider lanes, square accumulator
// ----------------------------------------------------------------------------
module vrmp_dpath #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  vrmp_pkg::vrmp_cmd_t                      cmd_i,
  output vrmp_pkg::vrmp_stat_t                     stat_o,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_z_i,
  input  logic                                     restart_i,
  output logic signed [vrmp_pkg::MEAN_WIDTH-1:0]   mean_x_o,
  output logic signed [vrmp_pkg::MEAN_WIDTH-1:0]   mean_y_o,
  output logic signed [vrmp_pkg::MEAN_WIDTH-1:0]   mean_z_o,
  output logic signed [SAMPLE_WIDTH-1:0]           peak_x_o,
  output logic signed [SAMPLE_WIDTH-1:0]           peak_y_o,
  output logic signed [SAMPLE_WIDTH-1:0]           peak_z_o,
  output logic        [COUNT_WIDTH-1:0]            samples_seen_o
);
  import vrmp_pkg::*;

  localparam int TW   = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int DW   = ((TW > MEAN_WIDTH) ? TW : MEAN_WIDTH) + 1;
  localparam int SUMW = DW + 2;
  localparam int SQW  = 2 * SAMPLE_WIDTH + 2;
  localparam int STW  = $clog2(DW);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [MEAN_WIDTH-1:0]  MEAN_MAX = {1'b0, {(MEAN_WIDTH-1){1'b1}}};
  localparam logic [MEAN_WIDTH-1:0]  MEAN_MIN = {1'b1, {(MEAN_WIDTH-1){1'b0}}};

  // statistics state
  logic [COUNT_WIDTH-1:0]  cnt_q;
  logic [MEAN_WIDTH-1:0]   mean_q    [NUM_AXES];
  logic [SQW-1:0]          peak_sq_q;
  logic [SAMPLE_WIDTH-1:0] peak_q    [NUM_AXES];

  // per item working registers
  logic [SAMPLE_WIDTH-1:0] smp_q     [NUM_AXES];
  logic [SAMPLE_WIDTH-1:0] mag_q     [NUM_AXES];
  logic [DW-1:0]           dd_q      [NUM_AXES];
  logic [COUNT_WIDTH-1:0]  rem_q     [NUM_AXES];
  logic [NUM_AXES-1:0]     neg_q;
  logic [SQW-1:0]          sq_q;
  logic [STW-1:0]          step_q;

  // result register
  logic [MEAN_WIDTH-1:0]   mean_out_q [NUM_AXES];
  logic [SAMPLE_WIDTH-1:0] peak_out_q [NUM_AXES];
  logic [COUNT_WIDTH-1:0]  cnt_out_q;

  logic [SAMPLE_WIDTH-1:0] smp_in     [NUM_AXES];
  logic [SAMPLE_WIDTH-1:0] mag_in     [NUM_AXES];
  logic [DW-1:0]           tgt        [NUM_AXES];
  logic [DW-1:0]           diff       [NUM_AXES];
  logic [DW-1:0]           diff_mag   [NUM_AXES];
  logic [COUNT_WIDTH:0]    trial      [NUM_AXES];
  logic [COUNT_WIDTH:0]    trial_sub  [NUM_AXES];
  logic [NUM_AXES-1:0]     qbit;
  logic [SUMW-1:0]         mean_ext   [NUM_AXES];
  logic [SUMW-1:0]         quot_ext   [NUM_AXES];
  logic [SUMW-1:0]         sum        [NUM_AXES];
  logic [MEAN_WIDTH-1:0]   mean_sat   [NUM_AXES];
  logic [COUNT_WIDTH-1:0]  cnt_next;
  logic [SAMPLE_WIDTH-1:0] mag_sel;
  logic [2*SAMPLE_WIDTH-1:0] sq_prod;
  logic                    peak_hit;

  assign smp_in[0] = sample_x_i;
  assign smp_in[1] = sample_y_i;
  assign smp_in[2] = sample_z_i;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag_in[i]    = smp_in[i][SAMPLE_WIDTH-1] ? (~smp_in[i] + 1'b1) : smp_in[i];
      tgt[i]       = {{(DW-SAMPLE_WIDTH){smp_q[i][SAMPLE_WIDTH-1]}}, smp_q[i]}
                     << FRACTION_BITS;
      diff[i]      = tgt[i] - {{(DW-MEAN_WIDTH){mean_q[i][MEAN_WIDTH-1]}}, mean_q[i]};
      diff_mag[i]  = diff[i][DW-1] ? (~diff[i] + 1'b1) : diff[i];
      trial[i]     = {rem_q[i], dd_q[i][DW-1]};
      qbit[i]      = (trial[i] >= {1'b0, cnt_q});
      trial_sub[i] = trial[i] - {1'b0, cnt_q};
      mean_ext[i]  = {{(SUMW-MEAN_WIDTH){mean_q[i][MEAN_WIDTH-1]}}, mean_q[i]};
      quot_ext[i]  = {{(SUMW-DW){1'b0}}, dd_q[i]};
      sum[i]       = neg_q[i] ? (mean_ext[i] - quot_ext[i]) : (mean_ext[i] + quot_ext[i]);
      if ((&sum[i][SUMW-1:MEAN_WIDTH-1]) || !(|sum[i][SUMW-1:MEAN_WIDTH-1])) begin
        mean_sat[i] = sum[i][MEAN_WIDTH-1:0];
      end else if (sum[i][SUMW-1]) begin
        mean_sat[i] = MEAN_MIN;
      end else begin
        mean_sat[i] = MEAN_MAX;
      end
    end
  end

  always_comb begin
    case (step_q[1:0])
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      2'd2:    mag_sel = mag_q[2];
      default: mag_sel = '0;
    endcase
  end

  assign sq_prod  = mag_sel * mag_sel;
  assign cnt_next = restart_i ? COUNT_WIDTH'(1)
                  : ((cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1);
  assign peak_hit = (sq_q > peak_sq_q);
  assign stat_o.div_last = (step_q == STW'(DW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      peak_sq_q <= '0;
      step_q    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        mean_q[i] <= '0;
        peak_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_next;
        if (restart_i) begin
          peak_sq_q <= '0;
          for (int i = 0; i < NUM_AXES; i++) begin
            mean_q[i] <= '0;
            peak_q[i] <= '0;
          end
        end
      end
      if (cmd_i.prep) begin
        step_q <= '0;
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.update) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          mean_q[i] <= mean_sat[i];
        end
        if (peak_hit) begin
          peak_sq_q <= sq_q;
          for (int i = 0; i < NUM_AXES; i++) begin
            peak_q[i] <= smp_q[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        smp_q[i] <= smp_in[i];
        mag_q[i] <= mag_in[i];
      end
    end
    if (cmd_i.prep) begin
      sq_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        dd_q[i]  <= diff_mag[i];
        neg_q[i] <= diff[i][DW-1];
        rem_q[i] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (step_q < STW'(NUM_AXES)) begin
        sq_q <= sq_q + SQW'(sq_prod);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        dd_q[i]  <= {dd_q[i][DW-2:0], qbit[i]};
        rem_q[i] <= qbit[i] ? trial_sub[i][COUNT_WIDTH-1:0] : trial[i][COUNT_WIDTH-1:0];
      end
    end
    if (cmd_i.out_load) begin
      cnt_out_q <= cnt_q;
      for (int i = 0; i < NUM_AXES; i++) begin
        mean_out_q[i] <= mean_q[i];
        peak_out_q[i] <= peak_q[i];
      end
    end
  end

  assign mean_x_o       = mean_out_q[0];
  assign mean_y_o       = mean_out_q[1];
  assign mean_z_o       = mean_out_q[2];
  assign peak_x_o       = peak_out_q[0];
  assign peak_y_o       = peak_out_q[1];
  assign peak_z_o       = peak_out_q[2];
  assign samples_seen_o = cnt_out_q;

endmodule

### sv/vector_running_mean_peak_capture_top.sv
// ----------------------------------------------------------------------------
// vector_running_mean_peak_capture_top
// per-axis cumulative mean and peak-magnitude vector hold for three-axis samples
//
// One sample is taken at a time and each produces one result. An item is
// accepted, the mean difference is prepared, the quotients are formed in the
// restoring dividers and the mean and peak are updated; the item then moves to
// the result register once that register is free or being read. The three
// divider lanes are D = max(SAMPLE_WIDTH + FRACTION_BITS, 32) + 1 bits wide (D
// is 33 at the defaults); they run side by side and produce one quotient bit
// per cycle. The sum of squares uses one shared multiplier at the start of the
// divide, taking the axes in turn. A new sample is accepted while the previous
// result is still waiting in the result register.
// ----------------------------------------------------------------------------
module vector_running_mean_peak_capture_top #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vrmp_in_if.sink           in_i,
  vrmp_out_if.source        out_o
);
  import vrmp_pkg::*;

  vrmp_cmd_t  cmd;
  vrmp_stat_t stat;

  vrmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  vrmp_dpath #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .sample_x_i     (in_i.sample_x),
    .sample_y_i     (in_i.sample_y),
    .sample_z_i     (in_i.sample_z),
    .restart_i      (in_i.restart),
    .mean_x_o       (out_o.mean_x),
    .mean_y_o       (out_o.mean_y),
    .mean_z_o       (out_o.mean_z),
    .peak_x_o       (out_o.peak_x),
    .peak_y_o       (out_o.peak_y),
    .peak_z_o       (out_o.peak_z),
    .samples_seen_o (out_o.samples_seen)
  );

`ifndef NO_ASSERTIONS
  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten while occupied");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second request accepted during processing");
`endif

endmodule
